FILE: rtl/terminated_frame_extractor_core_assert.svh
// Assertion macros shared by the frame extractor checkers.
`ifndef TERMINATED_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define TERMINATED_FRAME_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("frame extractor check failed");

// Next-cycle implication, disabled while reset is low.
`define TFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("frame extractor check failed");

`endif

FILE: rtl/tfe_pkg.sv
// Shared types, constants and helpers of the terminated frame extractor.
package tfe_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned MaxDelim = 8;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    ReqData  = 2'd0,
    ReqEnd   = 2'd1,
    ReqDrain = 2'd2,
    ReqReset = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTermBytes   = 3'd0,
    CfgTermLen     = 3'd1,
    CfgPrefixBytes = 3'd2,
    CfgPrefixLen   = 3'd3,
    CfgHexMode     = 3'd4
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic clear;
    logic wr_first;
    logic wr_second;
    logic emit_start;
    logic by_term;
    logic rd_en;
    logic load_char;
    logic load_mark;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic hex;
    logic pfx_bad;
    logic term_hit;
    logic last_char;
    logic out_free;
  } status_t;

  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] n);
    return (n > LenW'(MaxDelim)) ? LenW'(MaxDelim) : n;
  endfunction

endpackage

FILE: rtl/tfe_ctrl.sv
// Sequencer of the frame extractor: append, check and emission steps.
module tfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic [1:0]          req_type_i,
  input  tfe_pkg::status_t    status_i,
  output logic                s_tready_o,
  output tfe_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StWrFirst,
    StWrSecond,
    StCheck,
    StEmitRd,
    StEmitLd,
    StMark
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          case (req_type_i)
            tfe_pkg::ReqData: begin
              state_d = StWrFirst;
            end
            tfe_pkg::ReqEnd: begin
              if (status_i.empty) begin
                state_d = StMark;
              end else begin
                cmd_o.emit_start = 1'b1;
                state_d          = StEmitRd;
              end
            end
            tfe_pkg::ReqDrain: begin
              if (!status_i.empty) begin
                cmd_o.emit_start = 1'b1;
                state_d          = StEmitRd;
              end
            end
            default: begin
              cmd_o.clear = 1'b1;
            end
          endcase
        end
      end
      StWrFirst: begin
        cmd_o.wr_first = 1'b1;
        state_d        = status_i.hex ? StWrSecond : StCheck;
      end
      StWrSecond: begin
        cmd_o.wr_second = 1'b1;
        state_d         = StCheck;
      end
      StCheck: begin
        // a prefix mismatch empties the buffer, so no terminator match follows
        if (status_i.pfx_bad) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end else if (status_i.term_hit) begin
          cmd_o.emit_start = 1'b1;
          cmd_o.by_term    = 1'b1;
          state_d          = StEmitRd;
        end else begin
          state_d = StIdle;
        end
      end
      StEmitRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StEmitLd;
      end
      StEmitLd: begin
        if (status_i.out_free) begin
          cmd_o.load_char = 1'b1;
          if (status_i.last_char) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      StMark: begin
        if (status_i.out_free) begin
          cmd_o.load_mark = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/tfe_datapath.sv
// Datapath of the frame extractor: config, buffer memory, match logic, output register.
module tfe_datapath #(
  parameter int unsigned BUF_DEPTH = tfe_pkg::BufDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tfe_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic [7:0]                    in_byte_i,
  input  tfe_pkg::cmd_t                 cmd_i,
  output tfe_pkg::status_t              status_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [7:0]                    m_tdata_o,
  output logic                          m_tlast_o,
  output logic [1:0]                    m_tuser_o
);

  localparam int unsigned AW   = $clog2(BUF_DEPTH);
  localparam int unsigned CW   = $clog2(BUF_DEPTH + 1);
  localparam int unsigned HW   = $clog2(tfe_pkg::MaxDelim);
  localparam int unsigned LenW = tfe_pkg::LenW;
  localparam int unsigned DW   = 8 * tfe_pkg::MaxDelim;

  // configuration
  logic [tfe_pkg::CfgW-1:0] term_bytes_q, prefix_bytes_q;
  logic [LenW-1:0]          term_len_q, prefix_len_q;
  logic                     hex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_bytes_q   <= '0;
      term_len_q     <= '0;
      prefix_bytes_q <= '0;
      prefix_len_q   <= '0;
      hex_q          <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfe_pkg::CfgTermBytes:   term_bytes_q   <= cfg_wdata_i;
        tfe_pkg::CfgTermLen:     term_len_q     <= cfg_wdata_i[LenW-1:0];
        tfe_pkg::CfgPrefixBytes: prefix_bytes_q <= cfg_wdata_i;
        tfe_pkg::CfgPrefixLen:   prefix_len_q   <= cfg_wdata_i[LenW-1:0];
        tfe_pkg::CfgHexMode:     hex_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input byte
  logic [7:0] byte_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      byte_q <= in_byte_i;
    end
  end

  // append path
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   need_sum;
  logic          ovf;
  logic [CW-1:0] wr_pos;
  logic [7:0]    wr_char;
  logic          wr_en;

  assign need_sum = {1'b0, count_q} + (hex_q ? (CW+1)'(2) : (CW+1)'(1));
  assign ovf      = need_sum > (CW+1)'(BUF_DEPTH);
  assign wr_en    = cmd_i.wr_first | cmd_i.wr_second;
  assign wr_pos   = cmd_i.wr_first ? (ovf ? '0 : count_q) : count_q;

  always_comb begin
    if (cmd_i.wr_first) begin
      wr_char = hex_q ? tfe_pkg::hex_digit(byte_q[7:4]) : byte_q;
    end else begin
      wr_char = tfe_pkg::hex_digit(byte_q[3:0]);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = wr_pos + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // frame memory, one write and one registered read per cycle
  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_q;
  logic [AW-1:0] rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_pos[AW-1:0]] <= wr_char;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  // copy of the frame head for the prefix check, last chars for the terminator
  logic [7:0]    head_q [tfe_pkg::MaxDelim];
  logic [DW-1:0] hist_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_q <= {wr_char, hist_q[DW-1:8]};
      if (wr_pos < CW'(tfe_pkg::MaxDelim)) begin
        head_q[wr_pos[HW-1:0]] <= wr_char;
      end
    end
  end

  logic [LenW-1:0] plen, tlen, tshift;
  logic [DW-1:0]   hist_sh;
  logic            head_diff, tail_eq;

  assign plen    = tfe_pkg::clamp_len(prefix_len_q);
  assign tlen    = tfe_pkg::clamp_len(term_len_q);
  assign tshift  = LenW'(tfe_pkg::MaxDelim) - tlen;
  // newest char sits in the top byte; align the last tlen chars to byte 0
  assign hist_sh = hist_q >> {tshift, 3'b000};

  always_comb begin
    head_diff = 1'b0;
    tail_eq   = 1'b1;
    for (int i = 0; i < int'(tfe_pkg::MaxDelim); i++) begin
      if ((LenW'(i) < plen) && (head_q[i] != prefix_bytes_q[8*i +: 8])) begin
        head_diff = 1'b1;
      end
      if ((LenW'(i) < tlen) && (hist_sh[8*i +: 8] != term_bytes_q[8*i +: 8])) begin
        tail_eq = 1'b0;
      end
    end
  end

  // emission
  logic by_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      by_term_q <= 1'b0;
    end else if (cmd_i.emit_start) begin
      rd_idx_q  <= '0;
      by_term_q <= cmd_i.by_term;
    end else if (cmd_i.load_char) begin
      rd_idx_q  <= rd_idx_q + AW'(1);
    end
  end

  // output register
  logic       m_valid_q;
  logic [7:0] m_data_q;
  logic       m_last_q;
  logic [1:0] m_user_q;
  logic       last_char;

  assign last_char = (CW'(rd_idx_q) + CW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_char || cmd_i.load_mark) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      m_data_q <= rd_data_q;
      m_last_q <= last_char;
      m_user_q <= {by_term_q, 1'b0};
    end else if (cmd_i.load_mark) begin
      m_data_q <= 8'h00;
      m_last_q <= 1'b1;
      m_user_q <= 2'b01;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_user_q;

  assign status_o.empty     = (count_q == '0);
  assign status_o.hex       = hex_q;
  assign status_o.pfx_bad   = (plen != '0) && (count_q >= CW'(plen)) && head_diff;
  assign status_o.term_hit  = (tlen != '0) && (count_q >= CW'(tlen)) && tail_eq;
  assign status_o.last_char = last_char;
  assign status_o.out_free  = !m_valid_q || m_tready_i;

endmodule

FILE: rtl/terminated_frame_extractor_core.sv
// Top level of the terminated frame extractor: controller plus datapath.
// Bytes come in on the slave stream (tuser = request kind, tdata = byte) and
// are appended to a frame buffer, raw or as two uppercase hex digits. A data
// item takes one buffer write per character, then a compare step for the
// prefix and terminator, which run on register copies of the frame head
// and of the last eight characters. A terminator match, an end event or a
// drain event sends the frame out on the master stream, each character
// through the buffer memory's registered read and then the load into the
// output register. An end event on an empty buffer gives one marker item,
// which waits while the output register is held; reset and empty drain
// events are handled in the idle state. No input item is taken while a
// frame is going out. The buffer memory needs no clearing pass after reset.
module terminated_frame_extractor_core #(
  parameter int unsigned BUF_DEPTH = tfe_pkg::BufDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [tfe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tfe_pkg::CfgW-1:0]    cfg_wdata_i,
  // input stream
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [7:0]                  s_tdata_i,  // [7:0] in_byte
  input  logic [1:0]                  s_tuser_i,  // [1:0] req_type
  // output stream
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [7:0]                  m_tdata_o,  // [7:0] out_char
  output logic                        m_tlast_o,
  output logic [1:0]                  m_tuser_o   // [0] empty_frame, [1] by_terminator
);

  tfe_pkg::cmd_t    cmd;
  tfe_pkg::status_t status;

  tfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .req_type_i (s_tuser_i),
    .status_i   (status),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  tfe_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule

FILE: rtl/tfe_checker.sv
// Port-level checker of the frame extractor and its bind to the top level.
`include "terminated_frame_extractor_core_assert.svh"

module tfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_o,
  input logic [1:0] s_tuser_i,
  input logic       m_tvalid_o,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_o,
  input logic       m_tlast_o,
  input logic [1:0] m_tuser_o
);

  logic        data_acc;
  logic        marker_ok;
  logic [10:0] m_item;

  assign data_acc  = s_tvalid_i && s_tready_o && (s_tuser_i == tfe_pkg::ReqData);
  assign marker_ok = m_tlast_o && (m_tdata_o == 8'h00) && !m_tuser_o[1];
  assign m_item    = {m_tdata_o, m_tlast_o, m_tuser_o};

  // an accepted data item always keeps the block busy in the next cycle
  `TFE_ASSERT_NXT(a_busy_after_data, clk_i, rst_ni, data_acc, !s_tready_o)

  // the empty marker is a lone zero character, never a terminator frame
  `TFE_ASSERT_IMP(a_marker_form, clk_i, rst_ni, m_tvalid_o && m_tuser_o[0], marker_ok)

  // a stalled output item holds
  `TFE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_item))

endmodule

bind terminated_frame_extractor_core tfe_checker u_tfe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tuser_i  (s_tuser_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tlast_o  (m_tlast_o),
  .m_tuser_o  (m_tuser_o)
);

FILE: tb/tb.sv
// Self-checking testbench for the terminated frame extractor core.
`timescale 1ns / 1ps

module tb;

  localparam int ClkPeriod  = 8;
  localparam int CycleLimit = 600000;
  localparam int DrainSlack = 16;     // covers a hex data item plus margin
  localparam int RandItems  = 80;
  localparam int HoldCycles = 300;    // long receiver hold-off

  localparam int unsigned CfgW     = tfe_pkg::CfgW;
  localparam int unsigned LenW     = tfe_pkg::LenW;
  localparam int unsigned CfgIdxW  = tfe_pkg::CfgIdxW;
  localparam int unsigned BufDepth = tfe_pkg::BufDepth;
  localparam int unsigned MaxDelim = tfe_pkg::MaxDelim;

  // One emitted character as seen on the master stream.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic       by_term;
  } frame_char_t;

  // DUT ports; all inputs are known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               s_tvalid_i  = 1'b0;
  logic               s_tready_o;
  logic [7:0]         s_tdata_i   = '0;  // [7:0] in_byte
  logic [1:0]         s_tuser_i   = '0;  // [1:0] req_type
  logic               m_tvalid_o;
  logic               m_tready_i  = 1'b0;
  logic [7:0]         m_tdata_o;         // [7:0] out_char
  logic               m_tlast_o;
  logic [1:0]         m_tuser_o;         // [0] empty_frame, [1] by_terminator

  terminated_frame_extractor_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame predictor: shadow registers, pending character buffer, and the queue
  // of characters the block still owes us.
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] term_bytes_r   = '0;
  logic [LenW-1:0] term_len_r     = '0;
  logic [CfgW-1:0] prefix_bytes_r = '0;
  logic [LenW-1:0] prefix_len_r   = '0;
  logic            hex_r          = 1'b0;

  logic [7:0]  pend_buf [BufDepth];
  int          pend_cnt = 0;
  frame_char_t frame_chars_q [$];

  int fail_cnt   = 0;
  int items_sent = 0;

  // ASCII hex digit, uppercase
  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n > 4'd9) ? 8'd55 + 8'(n) : 8'd48 + 8'(n);
  endfunction

  // lengths above the delimiter limit saturate
  function automatic int delim_chars(logic [LenW-1:0] n);
    return (n > LenW'(MaxDelim)) ? int'(MaxDelim) : int'(n);
  endfunction

  function automatic void append_char(logic [7:0] c);
    if (pend_cnt < int'(BufDepth)) begin
      pend_buf[pend_cnt] = c;
      pend_cnt++;
    end
  endfunction

  // Queue the whole pending frame, one item per character, and clear it.
  function automatic void emit_pending(logic by_term);
    for (int k = 0; k < pend_cnt; k++) begin
      frame_chars_q.push_back('{ch: pend_buf[k], last: (k == pend_cnt - 1),
                                empty: 1'b0, by_term: by_term});
    end
    pend_cnt = 0;
  endfunction

  // Apply one accepted input item to the predictor.
  function automatic void cut_frames(tfe_pkg::req_e req, logic [7:0] b);
    int plen;
    int tlen;
    int base;
    bit hit;
    case (req)
      tfe_pkg::ReqReset: pend_cnt = 0;
      tfe_pkg::ReqDrain: begin
        if (pend_cnt > 0) emit_pending(1'b0);
      end
      tfe_pkg::ReqEnd: begin
        if (pend_cnt > 0) begin
          emit_pending(1'b0);
        end else begin
          // empty marker
          frame_chars_q.push_back('{ch: 8'h00, last: 1'b1, empty: 1'b1, by_term: 1'b0});
        end
      end
      default: begin
        // overflow: drop what is pending, new characters start afresh
        if (pend_cnt + (hex_r ? 2 : 1) > int'(BufDepth)) pend_cnt = 0;
        if (hex_r) begin
          append_char(hex_char(b[7:4]));
          append_char(hex_char(b[3:0]));
        end else begin
          append_char(b);
        end
        plen = delim_chars(prefix_len_r);
        if (plen > 0 && pend_cnt >= plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++) begin
            if (pend_buf[i] != prefix_bytes_r[8*i +: 8]) hit = 1'b0;
          end
          if (!hit) pend_cnt = 0;
        end
        tlen = delim_chars(term_len_r);
        if (tlen > 0 && pend_cnt >= tlen) begin
          base = pend_cnt - tlen;
          hit  = 1'b1;
          for (int i = 0; i < tlen; i++) begin
            if (pend_buf[base + i] != term_bytes_r[8*i +: 8]) hit = 1'b0;
          end
          if (hit) emit_pending(1'b1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output item is matched against the oldest
  // queued character.
  // ---------------------------------------------------------------------------
  frame_char_t want;
  frame_char_t got;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{ch: m_tdata_o, last: m_tlast_o, empty: m_tuser_o[0], by_term: m_tuser_o[1]};
      if (frame_chars_q.size() == 0) begin
        $display("%0t: unexpected item char %02h last %0b empty %0b term %0b",
                 $time, got.ch, got.last, got.empty, got.by_term);
        fail_cnt++;
      end else begin
        want = frame_chars_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                   $time, want.ch, want.last, want.empty, want.by_term,
                   got.ch, got.last, got.empty, got.by_term);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  int cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("terminated_frame_extractor_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: picks a new stall pattern whenever its random run ends; a test
  // can ask for one long hold-off, which is counted down here.
  // ---------------------------------------------------------------------------
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int rx_left       = 0;
  int rx_period     = 2;
  int rx_tick       = 0;

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_left   = $urandom_range(20, 200);
        rx_period = $urandom_range(2, 7);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0:       m_tready_i <= 1'b1;                      // no stalls at all
        1:       m_tready_i <= 1'($urandom_range(0, 1));  // heavy random stalls
        2:       m_tready_i <= ($urandom_range(0, 4) != 0);
        default: m_tready_i <= ((rx_tick % rx_period) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. gapless keeps valid
  // high from item to item.
  // ---------------------------------------------------------------------------
  bit gapless    = 1'b0;
  int burst_left = 0;

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(input tfe_pkg::req_e req, input logic [7:0] b);
    int gap;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= req;
    s_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    cut_frames(req, b);
    items_sent++;
    @(negedge clk_i);
    if (!gapless) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
        s_tvalid_i <= 1'b0;
        s_tdata_i  <= 8'($urandom);    // noise while idle
        repeat (gap) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop offering items and wait until every owed character has arrived.
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (frame_chars_q.size() != 0) @(negedge clk_i);
    repeat (DrainSlack) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    case (idx)
      tfe_pkg::CfgTermBytes:   term_bytes_r   = val;
      tfe_pkg::CfgTermLen:     term_len_r     = val[LenW-1:0];
      tfe_pkg::CfgPrefixBytes: prefix_bytes_r = val;
      tfe_pkg::CfgPrefixLen:   prefix_len_r   = val[LenW-1:0];
      tfe_pkg::CfgHexMode:     hex_r          = val[0];
      default: ;      // unused index, no effect
    endcase
  endtask

  // Program all registers once the block is idle.
  task automatic set_framing(input logic hex, input logic [CfgW-1:0] tbytes,
                             input logic [CfgW-1:0] tlen, input logic [CfgW-1:0] pbytes,
                             input logic [CfgW-1:0] plen);
    wait_idle();
    write_cfg(tfe_pkg::CfgTermBytes, tbytes);
    write_cfg(tfe_pkg::CfgTermLen, tlen);
    write_cfg(tfe_pkg::CfgPrefixBytes, pbytes);
    write_cfg(tfe_pkg::CfgPrefixLen, plen);
    write_cfg(tfe_pkg::CfgHexMode, {63'b0, hex});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: no terminator, no prefix, raw mode; only events cut frames.
  task automatic test_defaults();
    send_item(tfe_pkg::ReqEnd, 8'hA5);     // empty buffer: marker
    send_item(tfe_pkg::ReqDrain, 8'h5A);   // empty buffer: nothing
    send_item(tfe_pkg::ReqReset, 8'hFF);
    send_item(tfe_pkg::ReqData, 8'h00);
    send_item(tfe_pkg::ReqData, 8'hFF);
    send_item(tfe_pkg::ReqEnd, 8'h00);     // two-char flush
    send_item(tfe_pkg::ReqData, 8'h5A);
    send_item(tfe_pkg::ReqDrain, 8'h00);   // one-char flush
    send_item(tfe_pkg::ReqDrain, 8'h00);
    send_item(tfe_pkg::ReqData, 8'h33);
    send_item(tfe_pkg::ReqReset, 8'h00);   // buffer dropped, nothing out
    send_item(tfe_pkg::ReqEnd, 8'h00);     // marker again
  endtask

  // CR LF terminator, including a buffer shorter than the terminator.
  task automatic test_terminator();
    set_framing(1'b0, 64'h0A0D, 64'd2, 64'h0, 64'd0);
    send_item(tfe_pkg::ReqData, 8'h0A);    // 1 char < term length, no check
    send_item(tfe_pkg::ReqData, 8'h4F);
    send_item(tfe_pkg::ReqData, 8'h4B);
    send_item(tfe_pkg::ReqData, 8'h0D);
    send_item(tfe_pkg::ReqData, 8'h0A);    // cut on terminator
    send_item(tfe_pkg::ReqData, 8'h0D);
    send_item(tfe_pkg::ReqData, 8'h0A);    // terminator alone is a frame
    send_item(tfe_pkg::ReqData, 8'h0D);
    send_item(tfe_pkg::ReqDrain, 8'h00);
  endtask

  // "$G" prefix with CR LF terminator: good frame, mismatches, short buffer.
  task automatic test_prefix();
    set_framing(1'b0, 64'h0A0D, 64'd2, 64'h4724, 64'd2);
    send_item(tfe_pkg::ReqData, 8'h24);
    send_item(tfe_pkg::ReqData, 8'h47);
    send_item(tfe_pkg::ReqData, 8'h78);
    send_item(tfe_pkg::ReqData, 8'h0D);
    send_item(tfe_pkg::ReqData, 8'h0A);
    send_item(tfe_pkg::ReqData, 8'h24);
    send_item(tfe_pkg::ReqData, 8'h58);    // prefix mismatch clears
    send_item(tfe_pkg::ReqData, 8'h47);    // shorter than prefix, kept
    send_item(tfe_pkg::ReqData, 8'h78);    // now mismatch, cleared
    send_item(tfe_pkg::ReqData, 8'h24);
    send_item(tfe_pkg::ReqEnd, 8'h00);     // short frame flushed
  endtask

  // Hex expansion with a "0A" terminator.
  task automatic test_hex_mode();
    set_framing(1'b1, 64'h4130, 64'd2, 64'h0, 64'd0);
    send_item(tfe_pkg::ReqData, 8'h12);
    send_item(tfe_pkg::ReqData, 8'hAB);
    send_item(tfe_pkg::ReqData, 8'h0A);    // "12AB0A"
    send_item(tfe_pkg::ReqData, 8'hF0);
    send_item(tfe_pkg::ReqDrain, 8'h00);
    send_item(tfe_pkg::ReqData, 8'h00);
    send_item(tfe_pkg::ReqReset, 8'h00);
    send_item(tfe_pkg::ReqEnd, 8'h00);
  endtask

  // Full-width prefix and terminator, saturating lengths, masked length bits,
  // and writes to unused register indexes.
  task automatic test_extremes();
    set_framing(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_0000_000F,
                64'h0, 64'h0000_0000_0000_0009);
    repeat (8) send_item(tfe_pkg::ReqData, 8'h00);
    repeat (8) send_item(tfe_pkg::ReqData, 8'hFF);   // 16-char frame on terminator
    send_item(tfe_pkg::ReqData, 8'h01);
    send_item(tfe_pkg::ReqEnd, 8'h00);
    wait_idle();
    for (int k = int'(tfe_pkg::CfgHexMode) + 1; k < 2 ** CfgIdxW; k++) begin
      write_cfg(CfgIdxW'(k), {$urandom, $urandom});
    end
    // same frame again: unused writes must not have disturbed anything
    repeat (8) send_item(tfe_pkg::ReqData, 8'h00);
    repeat (8) send_item(tfe_pkg::ReqData, 8'hFF);
  endtask

  // Buffer overflow in hex and raw mode.
  task automatic test_overflow();
    set_framing(1'b1, 64'h0, 64'd0, 64'h0, 64'd0);
    repeat (33) send_item(tfe_pkg::ReqData, 8'($urandom));   // 33rd byte starts afresh
    send_item(tfe_pkg::ReqEnd, 8'h00);
    set_framing(1'b0, 64'h0, 64'd0, 64'h0, 64'd0);
    repeat (65) send_item(tfe_pkg::ReqData, 8'($urandom));
    send_item(tfe_pkg::ReqDrain, 8'h00);
  endtask

  // Long receiver hold-off while the sender keeps offering: the output side
  // backs up and the input side has to stall.
  task automatic test_backpressure();
    set_framing(1'b0, 64'h0A, 64'd1, 64'h0, 64'd0);
    gapless = 1'b1;
    hold_requests++;
    repeat (6) begin
      repeat (6) send_item(tfe_pkg::ReqData, 8'($urandom_range(8'h20, 8'h7E)));
      send_item(tfe_pkg::ReqData, 8'h0A);
    end
    gapless = 1'b0;
    wait_idle();
  endtask

  // One random configuration and a run of mostly well-formed frames:
  // prefix, random payload, terminator, mixed with noise and broken frames.
  task automatic run_random_phase(input int n_items);
    logic [7:0]      tsrc [8];
    logic [7:0]      psrc [8];
    logic [CfgW-1:0] tword;
    logic [CfgW-1:0] pword;
    logic [CfgW-1:0] tl_wr;
    int hex;
    int tn;
    int pn;
    int pay;
    int pick;
    int cut;
    int part;
    int start;
    hex = $urandom_range(0, 1);
    pick = $urandom_range(0, 7);
    if (pick == 1) begin
      tn = hex ? 4 : 8;     // full-width terminator
    end else if (hex) begin
      tn = $urandom_range(1, 3);
    end else begin
      tn = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    end
    pn = ($urandom_range(0, 1) == 0) ? 0 : (hex ? $urandom_range(1, 2) : $urandom_range(1, 3));
    if (pn > 0 && $urandom_range(0, 7) == 0) pn = hex ? 4 : 8;
    for (int k = 0; k < 8; k++) begin
      tsrc[k] = 8'($urandom);
      psrc[k] = 8'($urandom);
    end
    // delimiter characters as they will appear in the buffer
    for (int k = 0; k < 8; k++) begin
      if (hex) begin
        tword[8*k +: 8] = hex_char((k % 2 == 0) ? tsrc[k/2][7:4] : tsrc[k/2][3:0]);
        pword[8*k +: 8] = hex_char((k % 2 == 0) ? psrc[k/2][7:4] : psrc[k/2][3:0]);
      end else begin
        tword[8*k +: 8] = tsrc[k];
        pword[8*k +: 8] = psrc[k];
      end
    end
    tl_wr = CfgW'(hex ? 2 * tn : tn);
    if (pick == 0) tl_wr = '0;                               // terminator off
    if (pick == 1) tl_wr = CfgW'($urandom_range(8, 15));     // saturating length
    if ($urandom_range(0, 3) == 0) tl_wr |= {$urandom, $urandom} & ~64'hF;
    set_framing(hex[0], tword, tl_wr, pword, CfgW'(hex ? 2 * pn : pn));
    gapless = ($urandom_range(0, 4) == 0);
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0:       send_item(tfe_pkg::ReqEnd, 8'($urandom));
          1:       send_item(tfe_pkg::ReqDrain, 8'($urandom));
          2:       send_item(tfe_pkg::ReqReset, 8'($urandom));
          default: send_item(tfe_pkg::ReqData, 8'($urandom));
        endcase
      end else begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pn) : -1;  // broken prefix
        for (int k = 0; k < pn; k++) begin
          send_item(tfe_pkg::ReqData, (k == cut) ? psrc[k] ^ 8'h01 : psrc[k]);
        end
        pick = $urandom_range(0, 19);
        pay = (pick < 16) ? $urandom_range(0, 6) :
              (pick < 19) ? $urandom_range(7, 20) : $urandom_range(21, 70);
        repeat (pay) send_item(tfe_pkg::ReqData, 8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          for (int k = 0; k < tn; k++) send_item(tfe_pkg::ReqData, tsrc[k]);
        end else begin
          // truncated terminator or none, then a flush event
          if (pick == 8) begin
            part = $urandom_range(0, tn - 1);
            for (int k = 0; k < part; k++) send_item(tfe_pkg::ReqData, tsrc[k]);
          end
          send_item(($urandom_range(0, 1) == 0) ? tfe_pkg::ReqEnd : tfe_pkg::ReqDrain,
                    8'($urandom));
        end
      end
    end
    gapless = 1'b0;
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < RandItems) run_random_phase($urandom_range(25, 45));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_terminator();
    test_prefix();
    test_hex_mode();
    test_extremes();
    test_overflow();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("terminated_frame_extractor_core verification clean");
    end else begin
      $display("terminated_frame_extractor_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tfe_pkg.sv
rtl/tfe_ctrl.sv
rtl/tfe_datapath.sv
rtl/terminated_frame_extractor_core.sv
rtl/tfe_checker.sv
tb/tb.sv
